// ===== rtl/tdc_readout_word_checker_core_defines.svh =====
// assertion helpers for the readout word checker
// each expects clk and rst_n in the scope of use
`ifndef TDC_READOUT_WORD_CHECKER_CORE_DEFINES_SVH
`define TDC_READOUT_WORD_CHECKER_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define TRWC_AST_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdc readout checker: same-cycle check failed");

// condition implies consequence starting in the cycle after
`define TRWC_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdc readout checker: next-cycle check failed");

`endif

// ===== rtl/tdc_rwc_pkg.sv =====
package tdc_rwc_pkg;

  // queue between decode and check
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_MIN  = 2'd0,
    CFG_SLOT_MAX  = 2'd1,
    CFG_TRIG_TOL  = 2'd2
  } cfg_idx_t;

  // register reset values
  localparam logic [4:0] SLOT_MIN_RST = 5'd1;
  localparam logic [4:0] SLOT_MAX_RST = 5'd21;
  localparam logic [8:0] TRIG_TOL_RST = 9'd1;

  // raw time that marks an empty measurement
  localparam logic [15:0] TIME_INVALID = 16'hffff;

  // check status codes
  typedef enum logic [1:0] {
    ST_CHECKING = 2'd0,
    ST_PASSED   = 2'd1,
    ST_FAILED   = 2'd2,
    ST_SKIPPED  = 2'd3
  } check_status_t;

  typedef struct packed {
    logic [4:0] slot_min;
    logic [4:0] slot_max;
    logic [8:0] trig_time_tolerance;
  } cfg_t;

  typedef struct packed {
    logic [31:0] data_word;
    logic        first_word;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic        is_header;
    logic [4:0]  slot;
    logic [5:0]  channel;
    logic [15:0] time_value;
    logic [5:0]  event_number;
    logic [8:0]  trigger_time;
    logic [1:0]  header_flags;
    logic        hit_fifo_full;
    logic        output_fifo_full;
    logic        resolution_locked;
    logic        hit_valid;
    logic [1:0]  check_status;
  } out_item_t;

  // decoded word waiting for the checker
  typedef struct packed {
    out_item_t res;
    logic      first_word;
    logic      last_word;
  } dec_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/tdc_rwc_front.sv =====
module tdc_rwc_front (
  input  tdc_rwc_pkg::in_item_t  in_item,
  input  tdc_rwc_pkg::cfg_t      cfg,
  output tdc_rwc_pkg::dec_item_t dec_item
);
  import tdc_rwc_pkg::*;

  logic [31:0] w;
  logic        hdr;

  assign w   = in_item.data_word;
  assign hdr = ~w[23];

  // split the word into header or data fields
  always_comb begin
    dec_item                      = '0;
    dec_item.first_word           = in_item.first_word;
    dec_item.last_word            = in_item.last_word;
    dec_item.res.is_header        = hdr;
    dec_item.res.slot             = w[31:27];
    dec_item.res.hit_fifo_full    = w[24];
    dec_item.res.output_fifo_full = w[25];
    dec_item.res.resolution_locked = w[26];
    dec_item.res.check_status     = ST_CHECKING;
    if (hdr) begin
      dec_item.res.channel      = w[5:0];
      dec_item.res.event_number = w[21:16];
      dec_item.res.trigger_time = w[15:7];
      dec_item.res.header_flags = {w[6], w[22]};
    end else begin
      dec_item.res.channel    = w[21:16];
      dec_item.res.time_value = w[15:0];
      dec_item.res.hit_valid  = (w[31:27] >= cfg.slot_min) && (w[31:27] <= cfg.slot_max) &&
                                w[26] && (w[15:0] != TIME_INVALID);
    end
  end

endmodule

// ===== rtl/tdc_rwc_queue.sv =====
module tdc_rwc_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  tdc_rwc_pkg::dec_item_t push_item,
  input  logic                   pop,
  output tdc_rwc_pkg::dec_item_t pop_item,
  output tdc_rwc_pkg::q_status_t status
);
  import tdc_rwc_pkg::*;

  dec_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == QCNT_W'(QDEPTH));
  assign status.empty = (count_r == '0);
  assign pop_item     = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/tdc_rwc_back.sv =====
module tdc_rwc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tdc_rwc_pkg::cfg_t      cfg,
  input  tdc_rwc_pkg::dec_item_t q_item,
  input  logic                   q_empty,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tdc_rwc_pkg::out_item_t out_item
);
  import tdc_rwc_pkg::*;

  logic [5:0]    ref_evn_r, ref_evn_nxt;
  logic [8:0]    ref_trig_r, ref_trig_nxt;
  logic          failed_r, failed_nxt;
  logic          hdr_ok_r, hdr_ok_nxt;
  logic          out_valid_r;
  out_item_t     out_item_r, out_item_nxt;
  check_status_t status;
  logic [8:0]    diff;
  logic          hdr_pass;

  // take a word whenever the output register is free or draining
  assign pop       = !q_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // header comparison against the reference
  always_comb begin
    diff = (q_item.res.trigger_time >= ref_trig_r) ? q_item.res.trigger_time - ref_trig_r
                                                   : ref_trig_r - q_item.res.trigger_time;
    hdr_pass = (q_item.res.event_number == ref_evn_r) &&
               (diff <= cfg.trig_time_tolerance) && !q_item.res.header_flags[0];
  end

  // buffer check state and status
  always_comb begin
    ref_evn_nxt  = ref_evn_r;
    ref_trig_nxt = ref_trig_r;
    failed_nxt   = failed_r;
    hdr_ok_nxt   = hdr_ok_r;
    status       = ST_CHECKING;
    if (q_item.first_word) begin
      hdr_ok_nxt = 1'b0;
      if (q_item.res.is_header) begin
        failed_nxt   = 1'b0;
        ref_evn_nxt  = q_item.res.event_number;
        ref_trig_nxt = q_item.res.trigger_time;
      end else begin
        failed_nxt = 1'b1;
        status     = ST_FAILED;
      end
    end else if (failed_r) begin
      status = ST_SKIPPED;
    end else if (q_item.res.is_header) begin
      if (hdr_pass) begin
        hdr_ok_nxt = 1'b1;
      end else begin
        failed_nxt = 1'b1;
        status     = ST_FAILED;
      end
    end
    // closing word of a buffer still being checked
    if (q_item.last_word && !failed_nxt && status == ST_CHECKING) begin
      if (hdr_ok_nxt) begin
        status = ST_PASSED;
      end else begin
        failed_nxt = 1'b1;
        status     = ST_FAILED;
      end
    end
  end

  // decoded fields with the check status
  always_comb begin
    out_item_nxt              = q_item.res;
    out_item_nxt.check_status = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_evn_r   <= '0;
      ref_trig_r  <= '0;
      failed_r    <= 1'b0;
      hdr_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        ref_evn_r  <= ref_evn_nxt;
        ref_trig_r <= ref_trig_nxt;
        failed_r   <= failed_nxt;
        hdr_ok_r   <= hdr_ok_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (pop) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

// ===== rtl/tdc_readout_word_checker_core.sv =====
// Readout word checker: decodes one 32-bit converter word per cycle into
// header or data fields and checks each buffer (first word is the reference
// header, later headers must match it). Sustained rate is one word per clock
// unless in_stall or out_stall holds the flow; a word's result is registered:
// the decode stage writes a two-entry queue, and the checker pulls from that
// queue into the output register. in_stall rises only when the queue is full,
// so either side can hold off on its own. Configuration writes are always ready
// and must be issued while no words are in flight.
`include "tdc_readout_word_checker_core_defines.svh"

module tdc_readout_word_checker_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  tdc_rwc_pkg::in_item_t                   in_payload,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output tdc_rwc_pkg::out_item_t                  out_payload,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [tdc_rwc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tdc_rwc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tdc_rwc_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  dec_item_t dec_item;
  dec_item_t q_item;
  q_status_t q_stat;
  logic      in_accept;
  logic      q_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_stat.full;
  assign in_accept = in_valid && !in_stall;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SLOT_MIN: cfg_nxt.slot_min            = cfg_data[4:0];
        CFG_SLOT_MAX: cfg_nxt.slot_max            = cfg_data[4:0];
        CFG_TRIG_TOL: cfg_nxt.trig_time_tolerance = cfg_data[8:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slot_min            <= SLOT_MIN_RST;
      cfg_r.slot_max            <= SLOT_MAX_RST;
      cfg_r.trig_time_tolerance <= TRIG_TOL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // decode stage
  tdc_rwc_front u_front (
    .in_item  (in_payload),
    .cfg      (cfg_r),
    .dec_item (dec_item)
  );

  // decoupling queue
  tdc_rwc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_item (dec_item),
    .pop       (q_pop),
    .pop_item  (q_item),
    .status    (q_stat)
  );

  // buffer checker and result register
  tdc_rwc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_item    (q_item),
    .q_empty   (q_stat.empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_payload)
  );

  // checks
  `TRWC_AST_NEXT(a_empty_path_latency, in_accept && q_stat.empty && !out_valid, ##1 out_valid)
  `TRWC_AST_SAME(a_data_no_hdr_fields, out_valid && !out_payload.is_header,
                 out_payload.event_number == '0 && out_payload.trigger_time == '0 &&
                 out_payload.header_flags == '0)
  `TRWC_AST_SAME(a_hdr_no_hit, out_valid && out_payload.is_header,
                 !out_payload.hit_valid && out_payload.time_value == '0)

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import tdc_rwc_pkg::*;

  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 250;
  localparam int HOLD_CYCLES  = 64;
  localparam int MAX_REPORTS  = 10;

  // row of the directed stimulus table
  typedef struct {
    logic [31:0]   word;
    bit            first;
    bit            last;
    bit            pinned;
    check_status_t status;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_payload = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_payload;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SLOT_MIN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow copy of the block's registers and buffer state
  logic [4:0]  lo_slot = SLOT_MIN_RST;
  logic [4:0]  hi_slot = SLOT_MAX_RST;
  logic [8:0]  trig_tol = TRIG_TOL_RST;
  logic [5:0]  anchor_evn = '0;
  logic [8:0]  anchor_trig = '0;
  bit          buf_bad = 1'b0;
  bit          later_hdr_ok = 1'b0;

  out_item_t   pending_q[$];
  dir_row_t    dir_rows[26];

  int n_words = 0;
  int n_results = 0;
  int n_bad = 0;
  int n_settings = 0;
  int phase_words = 0;
  int burst_left = 0;
  int st_seen[4] = '{0, 0, 0, 0};
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  bit paused = 1'b0;

  tdc_readout_word_checker_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // header word: slot, chip flags {locked, out full, hit full}, overflow, event, trigger, xor, chan
  function automatic logic [31:0] mk_hdr(logic [4:0] slot, logic [2:0] chip, logic ovf,
                                         logic [5:0] evn, logic [8:0] trig, logic xr,
                                         logic [5:0] chan);
    return {slot, chip, 1'b0, ovf, evn, trig, xr, chan};
  endfunction

  // data word: slot, chip flags, spare bit 22, channel, raw time
  function automatic logic [31:0] mk_data(logic [4:0] slot, logic [2:0] chip, logic spare,
                                          logic [5:0] chan, logic [15:0] tval);
    return {slot, chip, 1'b1, spare, chan, tval};
  endfunction

  // decode one word and run the buffer integrity check on the shadow state
  function automatic out_item_t predict_word(in_item_t it);
    out_item_t   r;
    logic [31:0] w;
    int          diff;
    r = '0;
    w = it.data_word;
    r.is_header         = ~w[23];
    r.slot              = w[31:27];
    r.hit_fifo_full     = w[24];
    r.output_fifo_full  = w[25];
    r.resolution_locked = w[26];
    r.check_status      = ST_CHECKING;
    if (r.is_header) begin
      r.channel      = w[5:0];
      r.event_number = w[21:16];
      r.trigger_time = w[15:7];
      r.header_flags = {w[6], w[22]};
    end else begin
      r.channel    = w[21:16];
      r.time_value = w[15:0];
      r.hit_valid  = (r.slot >= lo_slot) && (r.slot <= hi_slot) && w[26] &&
                     (w[15:0] != TIME_INVALID);
    end

    if (it.first_word) begin
      later_hdr_ok = 1'b0;
      if (r.is_header) begin
        buf_bad     = 1'b0;
        anchor_evn  = r.event_number;
        anchor_trig = r.trigger_time;
      end else begin
        buf_bad        = 1'b1;
        r.check_status = ST_FAILED;
      end
    end else if (buf_bad) begin
      r.check_status = ST_SKIPPED;
    end else if (r.is_header) begin
      diff = int'(r.trigger_time) - int'(anchor_trig);
      if (diff < 0) diff = -diff;
      if (r.event_number == anchor_evn && diff <= int'(trig_tol) && !r.header_flags[0]) begin
        later_hdr_ok = 1'b1;
      end else begin
        buf_bad        = 1'b1;
        r.check_status = ST_FAILED;
      end
    end

    // closing word of a clean buffer needs at least one matching later header
    if (it.last_word && !buf_bad && r.check_status == ST_CHECKING) begin
      if (later_hdr_ok) begin
        r.check_status = ST_PASSED;
      end else begin
        buf_bad        = 1'b1;
        r.check_status = ST_FAILED;
      end
    end
    return r;
  endfunction

  // offer one word, with burst gaps, and record its expected result once taken
  task automatic push_word(logic [31:0] w, bit f, bit l, bit pin, check_status_t st);
    out_item_t want;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
    end
    in_valid   <= 1'b1;
    in_payload <= '{data_word: w, first_word: f, last_word: l};
    do @(posedge clk); while (in_stall);
    want = predict_word(in_payload);
    if (pin) want.check_status = st;
    pending_q.push_back(want);
    n_words++;
    phase_words++;
  endtask

  // hold the input idle until every outstanding result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SLOT_MIN: lo_slot = val[4:0];
      CFG_SLOT_MAX: hi_slot = val[4:0];
      CFG_TRIG_TOL: trig_tol = val;
      default: ;
    endcase
  endtask

  // upper data bits of the slot registers get junk, only the low five count
  task automatic set_config(logic [4:0] lo, logic [4:0] hi, logic [8:0] tol);
    write_reg(CFG_SLOT_MIN, {4'($urandom), lo});
    write_reg(CFG_SLOT_MAX, {4'($urandom), hi});
    write_reg(CFG_TRIG_TOL, tol);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // one buffer: mostly well formed with random content, some broken, some noise
  task automatic send_buffer();
    int          len;
    int          d;
    int          span;
    int          t;
    logic [5:0]  evn;
    logic [8:0]  trig;
    logic [31:0] w;
    bit          no_first;
    bit          no_last;
    if ($urandom_range(0, 99) < 8) begin
      push_word($urandom, 1'($urandom), 1'($urandom), 1'b0, ST_CHECKING);
      return;
    end
    len      = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 7);
    evn      = 6'($urandom);
    trig     = 9'($urandom);
    no_first = ($urandom_range(0, 19) == 0);
    no_last  = ($urandom_range(0, 9) == 0);
    span     = int'(trig_tol) + 2;
    for (int i = 0; i < len; i++) begin
      if (i == 0 && $urandom_range(0, 14) != 0) begin
        w = mk_hdr(5'($urandom), 3'($urandom), 1'($urandom), evn, trig, 1'($urandom),
                   6'($urandom));
      end else if (i > 0 && $urandom_range(0, 2) == 0) begin
        // later header, trigger time spread around the tolerance edge
        d = int'($urandom_range(0, 2 * span)) - span;
        t = ((int'(trig) + d) % 512 + 512) % 512;
        w = mk_hdr(5'($urandom), 3'($urandom), ($urandom_range(0, 11) == 0),
                   ($urandom_range(0, 9) == 0) ? 6'($urandom) : evn, 9'(t),
                   1'($urandom), 6'($urandom));
      end else begin
        w = mk_data(5'($urandom),
                    ($urandom_range(0, 6) == 0) ? 3'($urandom) : {1'b1, 2'($urandom)},
                    1'($urandom), 6'($urandom),
                    ($urandom_range(0, 9) == 0) ? TIME_INVALID : 16'($urandom));
      end
      push_word(w, (i == 0) && !no_first, (i == len - 1) && !no_last, 1'b0, ST_CHECKING);
    end
  endtask

  // receiver stall pattern in segments, with a long hold when requested
  initial begin
    int seg_len;
    int seg_mode;
    int hold_left;
    int cyc;
    hold_left = 0;
    cyc = 0;
    forever begin
      seg_len  = $urandom_range(20, 150);
      seg_mode = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(posedge clk);
        cyc++;
        if (hold_req) begin
          hold_req  = 1'b0;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          out_stall <= 1'b1;
          hold_left--;
        end else begin
          case (seg_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((cyc % 5) < 2);
          endcase
        end
      end
    end
  end

  // result checker against the oldest expected request
  always @(posedge clk) begin
    out_item_t want;
    string     bad;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      st_seen[out_payload.check_status]++;
      if (pending_q.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS)
          $display("unexpected result %0d: got %h", n_results, out_payload);
      end else begin
        want = pending_q.pop_front();
        bad = "";
        if (want.is_header !== out_payload.is_header) bad = {bad, " is_header"};
        if (want.slot !== out_payload.slot) bad = {bad, " slot"};
        if (want.channel !== out_payload.channel) bad = {bad, " channel"};
        if (want.time_value !== out_payload.time_value) bad = {bad, " time_value"};
        if (want.event_number !== out_payload.event_number) bad = {bad, " event_number"};
        if (want.trigger_time !== out_payload.trigger_time) bad = {bad, " trigger_time"};
        if (want.header_flags !== out_payload.header_flags) bad = {bad, " header_flags"};
        if (want.hit_fifo_full !== out_payload.hit_fifo_full) bad = {bad, " hit_fifo_full"};
        if (want.output_fifo_full !== out_payload.output_fifo_full)
          bad = {bad, " output_fifo_full"};
        if (want.resolution_locked !== out_payload.resolution_locked)
          bad = {bad, " resolution_locked"};
        if (want.hit_valid !== out_payload.hit_valid) bad = {bad, " hit_valid"};
        if (want.check_status !== out_payload.check_status) bad = {bad, " check_status"};
        if (bad != "") begin
          n_bad++;
          if (n_bad <= MAX_REPORTS)
            $display("result %0d wrong in%s: expected %h got %h", n_results, bad, want,
                     out_payload);
        end
      end
    end
  end

  // run time limit
  initial begin
    #5_000_000;
    $display("[tdc_readout_word_checker_core] ERROR");
    $finish;
  end

  initial begin
    // directed rows, checked against reset register values
    dir_rows[0]  = '{mk_data(5, 3'b100, 0, 3, 16'h1234), 0, 0, 1, ST_CHECKING};
    dir_rows[1]  = '{mk_hdr(2, 0, 0, 0, 0, 0, 0), 0, 1, 1, ST_PASSED};
    dir_rows[2]  = '{mk_data(3, 3'b111, 0, 1, 16'h0000), 1, 0, 1, ST_FAILED};
    dir_rows[3]  = '{mk_hdr(3, 0, 0, 1, 1, 0, 0), 0, 1, 1, ST_SKIPPED};
    dir_rows[4]  = '{32'hff7f_ffff, 1, 0, 1, ST_CHECKING};
    dir_rows[5]  = '{32'hffff_ffff, 0, 0, 1, ST_CHECKING};
    dir_rows[6]  = '{mk_data(5, 3'b100, 0, 9, TIME_INVALID), 0, 0, 0, ST_CHECKING};
    dir_rows[7]  = '{mk_data(1, 3'b100, 0, 63, 16'h0000), 0, 0, 0, ST_CHECKING};
    dir_rows[8]  = '{mk_data(21, 3'b100, 1, 0, 16'hfffe), 0, 0, 0, ST_CHECKING};
    dir_rows[9]  = '{mk_data(22, 3'b111, 0, 5, 16'h0001), 0, 0, 0, ST_CHECKING};
    dir_rows[10] = '{mk_data(5, 3'b011, 0, 5, 16'h0001), 0, 0, 0, ST_CHECKING};
    dir_rows[11] = '{mk_hdr(31, 3'b111, 0, 63, 510, 1, 63), 0, 0, 0, ST_CHECKING};
    dir_rows[12] = '{mk_hdr(0, 0, 0, 63, 511, 0, 0), 0, 1, 1, ST_PASSED};
    dir_rows[13] = '{32'h0000_0000, 1, 0, 1, ST_CHECKING};
    dir_rows[14] = '{mk_hdr(0, 0, 0, 0, 2, 0, 0), 0, 0, 1, ST_FAILED};
    dir_rows[15] = '{mk_hdr(4, 0, 0, 5, 100, 0, 1), 1, 0, 1, ST_CHECKING};
    dir_rows[16] = '{mk_hdr(4, 0, 0, 6, 100, 0, 1), 0, 1, 1, ST_FAILED};
    dir_rows[17] = '{mk_hdr(4, 0, 0, 5, 100, 0, 1), 1, 0, 1, ST_CHECKING};
    dir_rows[18] = '{mk_hdr(4, 0, 1, 5, 100, 0, 1), 0, 0, 1, ST_FAILED};
    dir_rows[19] = '{mk_hdr(6, 3'b100, 0, 7, 200, 0, 2), 1, 0, 1, ST_CHECKING};
    dir_rows[20] = '{mk_hdr(6, 3'b100, 0, 7, 199, 1, 2), 0, 0, 0, ST_CHECKING};
    dir_rows[21] = '{mk_data(6, 3'b100, 0, 2, 16'h00ff), 0, 1, 1, ST_PASSED};
    dir_rows[22] = '{mk_data(6, 3'b100, 0, 2, 16'h0100), 0, 0, 1, ST_CHECKING};
    dir_rows[23] = '{mk_hdr(6, 3'b100, 0, 9, 3, 0, 2), 1, 0, 1, ST_CHECKING};
    dir_rows[24] = '{mk_data(6, 3'b100, 0, 2, 16'h0101), 0, 1, 1, ST_FAILED};
    dir_rows[25] = '{mk_hdr(6, 3'b100, 0, 9, 3, 0, 2), 1, 1, 1, ST_FAILED};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    burst_left = $urandom_range(1, 40);

    foreach (dir_rows[i])
      push_word(dir_rows[i].word, dir_rows[i].first, dir_rows[i].last, dir_rows[i].pinned,
                dir_rows[i].status);
    drain();

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(5'd0, 5'd31, 9'd0);
        1: set_config(5'd31, 5'd0, 9'd511);
        PHASES - 1: set_config(SLOT_MIN_RST, SLOT_MAX_RST, TRIG_TOL_RST);
        default: set_config(5'($urandom), 5'($urandom),
                            ($urandom_range(0, 3) == 0) ? 9'($urandom)
                                                        : 9'($urandom_range(0, 6)));
      endcase
      // back-pressure phase: receiver holds while the sender keeps offering
      if (p == 3) begin
        no_gaps  = 1'b1;
        hold_req = 1'b1;
      end
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        send_buffer();
        if (p == 4 && !paused && phase_words >= PHASE_WORDS / 2) begin
          paused = 1'b1;
          drain();
        end
      end
      no_gaps = 1'b0;
      drain();
    end

    repeat (8) @(posedge clk);
    $display("run covered %0d words under %0d register settings, %0d results checked",
             n_words, n_settings, n_results);
    $display("buffer status seen: checking %0d, passed %0d, failed %0d, skipped %0d",
             st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
    if (n_bad == 0)
      $display("[tdc_readout_word_checker_core] OK");
    else
      $display("[tdc_readout_word_checker_core] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tdc_rwc_pkg.sv
rtl/tdc_rwc_front.sv
rtl/tdc_rwc_queue.sv
rtl/tdc_rwc_back.sv
rtl/tdc_readout_word_checker_core.sv
sim/tb_top.sv
